// File: rtl/core/cbrf_pkg.sv
// ----------------------------------------------------------------------------
// cbrf_pkg
// Shared types and constants for the chunked byte ring FIFO.
// ----------------------------------------------------------------------------
package cbrf_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int LANES_DEFAULT = 8;

    localparam int OP_W  = 2;
    localparam int CNT_W = 4;
    localparam int CAP_W = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

endpackage

// File: rtl/core/chunked_byte_ring_fifo_top.sv
// Flow: an accepted push or pop of n > 0 bytes moves one byte per lane in
//   ST_MOVE, then ST_EMIT registers the result; any other transaction goes
//   straight to ST_EMIT. Throughput: one transaction at a time; the byte RAM
//   moves one byte per cycle in ST_MOVE; ST_EMIT waits for the output slot.
// Reset: pointers and fill count cleared, capacity set to 256; the byte
//   store is not cleared.
// ----------------------------------------------------------------------------
// chunked_byte_ring_fifo_top
// Byte ring FIFO moving chunks of up to LANES bytes per push or pop.
// ----------------------------------------------------------------------------
module chunked_byte_ring_fifo_top
    import cbrf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int LANES = LANES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CAP_W-1:0]     cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_opcode,
    input  logic [CNT_W-1:0]     s_byte_count,
    input  logic [8*LANES-1:0]   s_write_bytes,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CNT_W-1:0]     m_moved_count,
    output logic [8*LANES-1:0]   m_read_bytes,
    output logic [CAP_W-1:0]     m_fill_level,
    output logic [CAP_W-1:0]     m_free_space,
    output logic                 m_full_flag,
    output logic                 m_empty_flag
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CMP_W  = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;
    localparam logic [CNT_W-1:0] LANES_C = CNT_W'(LANES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg, cap_next;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CAP_W-1:0]     fill_reg, fill_next;
    opcode_t              op_reg, op_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     moved_reg, moved_next;
    logic [8*LANES-1:0]   wdata_reg, wdata_next;
    logic [8*LANES-1:0]   rbytes_reg, rbytes_next;
    logic [LANE_W-1:0]    lane_reg, lane_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [LANE_W-1:0]    rd_lane_reg, rd_lane_next;

    logic                 m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]     m_moved_reg, m_moved_next;
    logic [8*LANES-1:0]   m_rbytes_reg, m_rbytes_next;
    logic [CAP_W-1:0]     m_fill_reg, m_fill_next;
    logic [CAP_W-1:0]     m_free_reg, m_free_next;
    logic                 m_full_reg, m_full_next;
    logic                 m_empty_reg, m_empty_next;

    logic [CAP_W-1:0]     cap_eff;
    logic [CAP_W:0]       fill_sum;
    logic                 push_ok;
    logic                 pop_ok;

    logic                 ram_we;
    logic [PTR_W-1:0]     ram_waddr;
    logic [7:0]           ram_wdata;
    logic [PTR_W-1:0]     ram_raddr;
    logic [7:0]           ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p,
                                                 input logic [CAP_W-1:0] c);
        logic [CMP_W-1:0] inc;
        inc = CMP_W'(p) + CMP_W'(1);
        if (inc >= CMP_W'(c)) begin
            return '0;
        end
        return inc[PTR_W-1:0];
    endfunction

    cbrf_byte_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CAP_W'(1);
        end else if (32'(cap_reg) > DEPTH) begin
            cap_eff = CAP_W'(DEPTH);
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign fill_sum = {1'b0, fill_reg} + (CAP_W+1)'(s_byte_count);
    assign push_ok  = (s_byte_count <= LANES_C) && (fill_sum <= {1'b0, cap_eff});
    assign pop_ok   = (s_byte_count <= LANES_C) && (CAP_W'(s_byte_count) <= fill_reg);

    assign ram_waddr = wr_ptr_reg;
    assign ram_wdata = wdata_reg[8*lane_reg +: 8];
    assign ram_raddr = rd_ptr_reg;

    always_comb begin
        state_next    = state_reg;
        cap_next      = cap_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        fill_next     = fill_reg;
        op_next       = op_reg;
        n_next        = n_reg;
        moved_next    = moved_reg;
        wdata_next    = wdata_reg;
        rbytes_next   = rbytes_reg;
        lane_next     = lane_reg;
        rd_pend_next  = 1'b0;
        rd_lane_next  = lane_reg;
        m_valid_next  = m_valid_reg;
        m_moved_next  = m_moved_reg;
        m_rbytes_next = m_rbytes_reg;
        m_fill_next   = m_fill_reg;
        m_free_next   = m_free_reg;
        m_full_next   = m_full_reg;
        m_empty_next  = m_empty_reg;
        ram_we        = 1'b0;

        if (rd_pend_reg) begin
            rbytes_next[8*rd_lane_reg +: 8] = ram_rdata;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next     = opcode_t'(s_opcode);
                    n_next      = s_byte_count;
                    wdata_next  = s_write_bytes;
                    rbytes_next = '0;
                    lane_next   = '0;
                    moved_next  = '0;
                    state_next  = ST_EMIT;
                    case (opcode_t'(s_opcode))
                        OP_PUSH: begin
                            if (push_ok) begin
                                fill_next  = fill_sum[CAP_W-1:0];
                                moved_next = s_byte_count;
                                if (s_byte_count != '0) begin
                                    state_next = ST_MOVE;
                                end
                            end
                        end
                        OP_POP: begin
                            if (pop_ok) begin
                                fill_next  = fill_reg - CAP_W'(s_byte_count);
                                moved_next = s_byte_count;
                                if (s_byte_count != '0) begin
                                    state_next = ST_MOVE;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            wr_ptr_next = '0;
                            rd_ptr_next = '0;
                            fill_next   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MOVE: begin
                if (op_reg == OP_PUSH) begin
                    ram_we      = 1'b1;
                    wr_ptr_next = ptr_adv(wr_ptr_reg, cap_eff);
                end else begin
                    rd_pend_next = 1'b1;
                    rd_lane_next = lane_reg;
                    rd_ptr_next  = ptr_adv(rd_ptr_reg, cap_eff);
                end
                lane_next = lane_reg + LANE_W'(1);
                if (CNT_W'(lane_reg) == (n_reg - CNT_W'(1))) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!rd_pend_reg && (!m_valid_reg || m_ready)) begin
                    m_valid_next  = 1'b1;
                    m_moved_next  = moved_reg;
                    m_rbytes_next = rbytes_reg;
                    m_fill_next   = fill_reg;
                    m_free_next   = cap_eff - fill_reg;
                    m_full_next   = (fill_reg == cap_eff);
                    m_empty_next  = (fill_reg == '0);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            cap_next    = cfg_wr_data;
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            fill_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CAP_RESET;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            fill_reg    <= fill_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        n_reg        <= n_next;
        moved_reg    <= moved_next;
        wdata_reg    <= wdata_next;
        rbytes_reg   <= rbytes_next;
        lane_reg     <= lane_next;
        rd_lane_reg  <= rd_lane_next;
        m_moved_reg  <= m_moved_next;
        m_rbytes_reg <= m_rbytes_next;
        m_fill_reg   <= m_fill_next;
        m_free_reg   <= m_free_next;
        m_full_reg   <= m_full_next;
        m_empty_reg  <= m_empty_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_moved_count = m_moved_reg;
    assign m_read_bytes  = m_rbytes_reg;
    assign m_fill_level  = m_fill_reg;
    assign m_free_space  = m_free_reg;
    assign m_full_flag   = m_full_reg;
    assign m_empty_flag  = m_empty_reg;

endmodule

// File: rtl/core/cbrf_byte_ram.sv
// ----------------------------------------------------------------------------
// cbrf_byte_ram
// Byte-wide simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cbrf_byte_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/cbrf_checker.sv
// ----------------------------------------------------------------------------
// cbrf_checker
// Port-level assertions for the chunked byte ring FIFO.
// ----------------------------------------------------------------------------
module cbrf_checker
    import cbrf_pkg::*;
#(
    parameter int LANES = LANES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [CNT_W-1:0]     m_moved_count,
    input  logic [8*LANES-1:0]   m_read_bytes,
    input  logic [CAP_W-1:0]     m_fill_level,
    input  logic [CAP_W-1:0]     m_free_space,
    input  logic                 m_full_flag,
    input  logic                 m_empty_flag
);

    a_moved_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_moved_count <= CNT_W'(LANES)))
        else $error("moved count exceeds lane count");

    a_full_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_full_flag) |-> (m_free_space == '0))
        else $error("full flag with free space left");

    a_empty_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_empty_flag == (m_fill_level == '0)))
        else $error("empty flag disagrees with fill level");

    a_idle_rdata: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_moved_count == '0)) |-> (m_read_bytes == '0))
        else $error("read bytes nonzero on transaction that moved nothing");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_fill_level)))
        else $error("result dropped or changed while stalled");

endmodule

bind chunked_byte_ring_fifo_top cbrf_checker #(.LANES(LANES)) u_cbrf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_moved_count (m_moved_count),
    .m_read_bytes  (m_read_bytes),
    .m_fill_level  (m_fill_level),
    .m_free_space  (m_free_space),
    .m_full_flag   (m_full_flag),
    .m_empty_flag  (m_empty_flag)
);
